// ----- src/itaf_pkg.sv -----
// ----------------------------------------------------------------------------
// itaf_pkg
// Shared types, format codes and the digit-to-ASCII function of the integer
// to ASCII formatter.
// ----------------------------------------------------------------------------
package itaf_pkg;

    localparam int VALUE_W   = 32;
    localparam int ACTION_W  = 2;
    localparam int CHAR_W    = 8;
    localparam int POS_W     = 4;
    localparam int DEC_DIGITS = 10;
    localparam int HEX_DIGITS = 8;
    localparam int BCD_W     = 4 * DEC_DIGITS;
    localparam int CNT_W     = 4;
    localparam int BIT_W     = 5;

    // format codes
    localparam logic [ACTION_W-1:0] ACT_SDEC = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_UDEC = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LHEX = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_UHEX = 2'd3;

    localparam logic [CHAR_W-1:0] CHR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHR_LOWER_OFS = 8'd87;  // 'a' - 10
    localparam logic [CHAR_W-1:0] CHR_UPPER_OFS = 8'd55;  // 'A' - 10

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic skip_step;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    typedef struct packed {
        logic conv_done;
        logic top_zero;
        logic cnt_one;
        logic neg;
        logic hex;
        logic slot_free;
    } t_sts;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d,
                                                     input logic hex,
                                                     input logic upper);
        logic [CHAR_W-1:0] ext;
        ext = {4'd0, d};
        if (!hex || d < 4'd10) begin
            return CHR_ZERO + ext;
        end else if (upper) begin
            return CHR_UPPER_OFS + ext;
        end else begin
            return CHR_LOWER_OFS + ext;
        end
    endfunction

endpackage

// ----- src/integer_to_ascii_formatter.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// 32-bit value to ASCII text in signed/unsigned decimal or hex.
// ----------------------------------------------------------------------------
// One value enters per run and leaves as 1 to 11 character beats, most
// significant first, each with its position and a last flag. Decimal runs
// pass a load, a double-dabble conversion over all 32 value bits, a skip
// of leading zeros, a minus sign for a negative value and then the digits.
// Hex runs pass a load, a pass through the conversion state with no work,
// a skip of leading zeros and then the digits. Character beats stall while
// the output register is held; a new value is taken once the final
// character has been placed in the output register.
module integer_to_ascii_formatter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [itaf_pkg::ACTION_W-1:0] i_action,
    input  logic [itaf_pkg::VALUE_W-1:0]  i_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [itaf_pkg::CHAR_W-1:0]   o_character,
    output logic [itaf_pkg::POS_W-1:0]    o_position,
    output logic                          o_last
);
    import itaf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    itaf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    itaf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_action    (i_action),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_position  (o_position),
        .o_last      (o_last)
    );

endmodule

// ----- src/itaf_ctrl.sv -----
// ----------------------------------------------------------------------------
// itaf_ctrl
// Sequencer: conversion, leading-zero skip, sign and character emission.
// ----------------------------------------------------------------------------
module itaf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  itaf_pkg::t_sts i_sts,
    output itaf_pkg::t_cmd o_cmd
);
    import itaf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_CONV;
            end
            ST_CONV: begin
                if (i_sts.hex || i_sts.conv_done) n_state = ST_SKIP;
            end
            ST_SKIP: begin
                if (!i_sts.top_zero || i_sts.cnt_one) begin
                    n_state = i_sts.neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (i_sts.slot_free) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.slot_free && i_sts.cnt_one) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready          = (r_state == ST_IDLE);
        o_cmd.load       = (r_state == ST_IDLE) && i_valid;
        o_cmd.conv_step  = (r_state == ST_CONV) && !i_sts.hex;
        o_cmd.skip_step  = (r_state == ST_SKIP) && i_sts.top_zero && !i_sts.cnt_one;
        o_cmd.emit_sign  = (r_state == ST_SIGN) && i_sts.slot_free;
        o_cmd.emit_digit = (r_state == ST_EMIT) && i_sts.slot_free;
    end

`ifndef SYNTHESIS
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.conv_step, o_cmd.skip_step,
                  o_cmd.emit_sign, o_cmd.emit_digit}))
        else $error("more than one datapath command");
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_digit && i_sts.cnt_one) |=> (r_state == ST_IDLE))
        else $error("final character did not end the run");
    a_conv_to_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV && i_sts.conv_done) |=> (r_state == ST_SKIP))
        else $error("conversion did not end after the last bit");
`endif

endmodule

// ----- src/itaf_dp.sv -----
// ----------------------------------------------------------------------------
// itaf_dp
// Datapath: double-dabble digit register, digit counter and output register.
// ----------------------------------------------------------------------------
module itaf_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [itaf_pkg::ACTION_W-1:0]     i_action,
    input  logic [itaf_pkg::VALUE_W-1:0]      i_value,
    input  itaf_pkg::t_cmd                    i_cmd,
    output itaf_pkg::t_sts                    o_sts,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [itaf_pkg::CHAR_W-1:0]       o_character,
    output logic [itaf_pkg::POS_W-1:0]        o_position,
    output logic                              o_last
);
    import itaf_pkg::*;

    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [BCD_W-1:0]   adj;
    logic [VALUE_W-1:0] mag;
    logic [CNT_W-1:0]   r_cnt;
    logic [BIT_W-1:0]   r_bit;
    logic [POS_W-1:0]   r_pos;
    logic               r_neg;
    logic               r_hex;
    logic               r_upper;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_char;
    logic [POS_W-1:0]   r_out_pos;
    logic               r_last;
    logic               slot_free;
    logic               neg_in;
    logic               hex_in;

    assign neg_in    = (i_action == ACT_SDEC) && i_value[VALUE_W-1];
    assign hex_in    = (i_action == ACT_LHEX) || (i_action == ACT_UHEX);
    assign mag       = neg_in ? (~i_value + 1'b1) : i_value;
    assign slot_free = !r_out_valid || i_ready;

    // add three to every bcd digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            adj[i*4 +: 4] = (r_bcd[i*4 +: 4] >= 4'd5) ? r_bcd[i*4 +: 4] + 4'd3
                                                      : r_bcd[i*4 +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg   <= neg_in;
            r_hex   <= hex_in;
            r_upper <= (i_action == ACT_UHEX);
            r_bit   <= '0;
            r_pos   <= '0;
            r_bin   <= mag;
            if (hex_in) begin
                r_bcd <= {i_value, {(BCD_W-VALUE_W){1'b0}}};
                r_cnt <= CNT_W'(HEX_DIGITS);
            end else begin
                r_bcd <= '0;
                r_cnt <= CNT_W'(DEC_DIGITS);
            end
        end else if (i_cmd.conv_step) begin
            r_bcd <= {adj[BCD_W-2:0], r_bin[VALUE_W-1]};
            r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
            r_bit <= r_bit + 1'b1;
        end else if (i_cmd.skip_step || i_cmd.emit_digit) begin
            r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_pos     <= r_pos + 1'b1;
            r_out_pos <= r_pos;
            r_last    <= i_cmd.emit_digit && (r_cnt == CNT_W'(1));
            r_char    <= i_cmd.emit_sign ? CHR_MINUS
                         : digit_char(r_bcd[BCD_W-1 -: 4], r_hex, r_upper);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_sts.conv_done = (r_bit == BIT_W'(VALUE_W - 1));
        o_sts.top_zero  = (r_bcd[BCD_W-1 -: 4] == 4'd0);
        o_sts.cnt_one   = (r_cnt == CNT_W'(1));
        o_sts.neg       = r_neg;
        o_sts.hex       = r_hex;
        o_sts.slot_free = slot_free;
    end

    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_position  = r_out_pos;
    assign o_last      = r_last;

endmodule

// ----- dv/integer_to_ascii_formatter_tb.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_tb
// Self-checking bench for the integer to ASCII formatter. Values go in with a
// format code, and each character beat that comes out is checked against a
// table text or a local formatter for its code, position and last flag. A
// short table of corner values comes first, then random values under several
// idle and stall mixes, and a long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_tb;
    import itaf_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 400;
    localparam int TAIL_CYCLES   = 64;
    localparam int PHASE_VALUES  = 48;
    localparam int BURST_VALUES  = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int N_TABLE       = 22;

    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic [POS_W-1:0]  pos;
        logic              last;
    } t_char_beat;

    // empty text means the row is checked against the formatter below
    typedef struct {
        logic [ACTION_W-1:0] act;
        logic [VALUE_W-1:0]  val;
        string               text;
    } t_row;

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                i_valid  = 1'b0;
    logic                o_ready;
    logic [ACTION_W-1:0] i_action = '0;
    logic [VALUE_W-1:0]  i_value  = '0;
    logic                o_valid;
    logic                i_ready  = 1'b0;
    logic [CHAR_W-1:0]   o_character;
    logic [POS_W-1:0]    o_position;
    logic                o_last;

    t_char_beat expected_chars[$];
    t_char_beat head;
    int         mismatch_cnt   = 0;
    int         src_idle_pct   = 0;
    int         sink_stall_pct = 0;
    logic       hold_req       = 1'b0;
    int         hold_cnt;
    int         cycle_cnt      = 0;

    t_row corner_rows [N_TABLE] = '{
        '{ACT_SDEC, 32'h0000_0000, "0"},
        '{ACT_UDEC, 32'h0000_0000, "0"},
        '{ACT_LHEX, 32'h0000_0000, "0"},
        '{ACT_UHEX, 32'h0000_0000, "0"},
        '{ACT_SDEC, 32'h8000_0000, "-2147483648"},
        '{ACT_SDEC, 32'h7FFF_FFFF, "2147483647"},
        '{ACT_SDEC, 32'hFFFF_FFFF, "-1"},
        '{ACT_SDEC, 32'hFFFF_FFF6, "-10"},
        '{ACT_UDEC, 32'hFFFF_FFFF, "4294967295"},
        '{ACT_UDEC, 32'h8000_0000, "2147483648"},
        '{ACT_LHEX, 32'hFFFF_FFFF, "ffffffff"},
        '{ACT_UHEX, 32'hFFFF_FFFF, "FFFFFFFF"},
        '{ACT_LHEX, 32'h0000_0010, "10"},
        '{ACT_UHEX, 32'h0000_0010, "10"},
        '{ACT_LHEX, 32'h0000_000F, "f"},
        '{ACT_LHEX, 32'hDEAD_BEEF, "deadbeef"},
        '{ACT_UHEX, 32'hABCD_EF01, "ABCDEF01"},
        '{ACT_UDEC, 32'd9,         ""},
        '{ACT_UDEC, 32'd10,        ""},
        '{ACT_SDEC, 32'd1000000000, ""},
        '{ACT_UDEC, 32'h5555_5555, ""},
        '{ACT_SDEC, 32'hAAAA_AAAA, ""}
    };

    integer_to_ascii_formatter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_position  (o_position),
        .o_last      (o_last)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    function automatic void note_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
            $display("mismatch: %s", msg);
        end
    endfunction

    function automatic void queue_text(input string s);
        t_char_beat beat;
        for (int k = 0; k < s.len(); k++) begin
            beat.code = s[k];
            beat.pos  = POS_W'(k);
            beat.last = (k == s.len() - 1);
            expected_chars.push_back(beat);
        end
    endfunction

    // digits come out least significant first, so build the run from the front
    function automatic void queue_formatted(input logic [ACTION_W-1:0] act,
                                            input logic [VALUE_W-1:0] val);
        logic [CHAR_W-1:0]  run[$];
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] rem;
        logic [3:0]         nib;
        logic               neg;
        t_char_beat         beat;
        neg = (act == ACT_SDEC) && val[VALUE_W-1];
        mag = neg ? (~val + 32'd1) : val;
        do begin
            if (act == ACT_SDEC || act == ACT_UDEC) begin
                rem = mag % 32'd10;
                run.push_front(ASCII_ZERO + rem[CHAR_W-1:0]);
                mag = mag / 32'd10;
            end else begin
                nib = mag[3:0];
                if (nib < 4'd10) begin
                    run.push_front(ASCII_ZERO + {4'd0, nib});
                end else if (act == ACT_LHEX) begin
                    run.push_front(ASCII_LOWER_A + {4'd0, nib} - 8'd10);
                end else begin
                    run.push_front(ASCII_UPPER_A + {4'd0, nib} - 8'd10);
                end
                mag = mag >> 4;
            end
        end while (mag != 0);
        if (neg) begin
            run.push_front(ASCII_MINUS);
        end
        for (int k = 0; k < run.size(); k++) begin
            beat.code = run[k];
            beat.pos  = POS_W'(k);
            beat.last = (k == run.size() - 1);
            expected_chars.push_back(beat);
        end
    endfunction

    // mostly values that land near a change in run length
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] p;
        p = 32'd1;
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(255);
            2: return (32'd1 << $urandom_range(31)) - $urandom_range(1);
            3: begin
                repeat ($urandom_range(9)) p = p * 32'd10;
                return p + $urandom_range(2) - 32'd1;
            end
            4: return 32'd0 - $urandom_range(1000);
            default: return $urandom_range(15) << (4 * $urandom_range(7));
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_value(input logic [ACTION_W-1:0] act,
                              input logic [VALUE_W-1:0] val,
                              input string text);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_value  <= val;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        if (text.len() > 0) begin
            queue_text(text);
        end else begin
            queue_formatted(act, val);
        end
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_chars.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // receiver: random stalls, or one long hold-off when asked
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                for (hold_cnt = 1; hold_cnt < HOLD_CYCLES; hold_cnt++) begin
                    @(negedge i_clk);
                end
                hold_req <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_chars.size() == 0) begin
                note_mismatch($sformatf("unexpected beat char %h pos %0d last %0b",
                                        o_character, o_position, o_last));
            end else begin
                head = expected_chars.pop_front();
                if (head.code !== o_character || head.pos !== o_position
                        || head.last !== o_last) begin
                    note_mismatch($sformatf(
                        "expected char %h pos %0d last %0b, got %h pos %0d last %0b",
                        head.code, head.pos, head.last,
                        o_character, o_position, o_last));
                end
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < N_TABLE; r++) begin
            send_value(corner_rows[r].act, corner_rows[r].val, corner_rows[r].text);
        end
        drain();

        // no idling, sender idle, receiver stalling, both lightly
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct    = (ph == 1) ? 88 : (ph == 3) ? 16 : 0;
            sink_stall_pct <= (ph == 2) ? 88 : (ph == 3) ? 16 : 0;
            for (int n = 0; n < PHASE_VALUES; n++) begin
                send_value(2'($urandom_range(3)), pick_value(), "");
            end
            drain();
        end

        // output held off while values keep coming, so the input backs up
        src_idle_pct   = 0;
        sink_stall_pct <= 0;
        hold_req       <= 1'b1;
        for (int n = 0; n < BURST_VALUES; n++) begin
            send_value(2'($urandom_range(3)), pick_value(), "");
        end
        drain();

        sink_stall_pct <= 30;
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (expected_chars.size() != 0) begin
            note_mismatch($sformatf("%0d beats never arrived", expected_chars.size()));
        end
        if (mismatch_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/itaf_pkg.sv
src/itaf_ctrl.sv
src/itaf_dp.sv
src/integer_to_ascii_formatter.sv
dv/integer_to_ascii_formatter_tb.sv
